// File: rtl/uvep_pkg.sv
package uvep_pkg;

  localparam int ROT_BITS   = 30;
  localparam int MAX_POINTS = 63;

  // iteration counts of the shared unit
  localparam logic [6:0] MUL_ITERS  = 7'd32;
  localparam logic [6:0] DIV_ITERS  = 7'd64;
  localparam logic [6:0] SQRT_ITERS = 7'd33;

  // configuration register indexes
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_LINE_EXTENT = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

// File: rtl/uncertain_voronoi_edge_points_top.sv
// Channel  Dir  Word layout (lsb first)                                    Accept
// in_      in   ax32 ay32 bx32 by32 ua31 ub31 pad2                        tvalid & tready
// out_     out  lx32 ly32 rx32 ry32 a31 c31 idx6 pad4; tuser=empty; tlast tvalid & tready
// cfg_     in   index 0 point_count, 1 line_extent; data 31 bits          cfg_we
//
// One word in at a time: ready only while idle. A single sequencer drives one shared
// bit-serial unit for multiply, divide and square root. Result register decouples
// out_tready stalls from the input side.
// rst_n synchronous, active low; config regs reset to 21 and 6553600.
module uncertain_voronoi_edge_points_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // center_a_x, center_a_y, center_b_x, center_b_y,
                                   // uncert_a, uncert_b, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // left_x, left_y, right_x, right_y, half_radius_sum,
                                   // half_distance, point_index, zero pad
  output logic         out_tuser,  // empty_res
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_wdata
);
  import uvep_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_SQX   = 21'h000002,
    S_SQY   = 21'h000004,
    S_DIST  = 21'h000008,
    S_CS    = 21'h000010,
    S_SN    = 21'h000020,
    S_A2    = 21'h000040,
    S_C2    = 21'h000080,
    S_BF    = 21'h000100,
    S_STEP  = 21'h000200,
    S_COL   = 21'h000400,
    S_XSQ   = 21'h000800,
    S_YSQRT = 21'h001000,
    S_YMUL  = 21'h002000,
    S_YDIV  = 21'h004000,
    S_R1    = 21'h008000,
    S_R2    = 21'h010000,
    S_R3    = 21'h020000,
    S_R4    = 21'h040000,
    S_SUM   = 21'h080000,
    S_EMIT  = 21'h100000
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sh07FFFFFFF)       sat32 = 32'h7FFFFFFF;
    else if (v < -35'sh080000000) sat32 = 32'h80000000;
    else                          sat32 = v[31:0];
  endfunction

  state_t state_r, state_nxt;
  logic   iss_r, iss_nxt;
  logic [5:0]  pc_r, pc_nxt;
  logic [30:0] le_r, le_nxt;

  // item working registers
  logic [31:0] qx_r, qx_nxt, qy_r, qy_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic        sgx_r, sgx_nxt, sgy_r, sgy_nxt;
  logic [30:0] a_r, a_nxt;
  logic [64:0] sum_r, sum_nxt;
  logic [32:0] dist_r, dist_nxt;
  logic [30:0] csm_r, csm_nxt, snm_r, snm_nxt;
  logic [61:0] a2_r, a2_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic [31:0] bf_r, bf_nxt, stepm_r, stepm_nxt;
  logic        stepneg_r, stepneg_nxt;
  logic [32:0] xr_r, xr_nxt;
  logic [30:0] xc_r, xc_nxt, ym_r, ym_nxt;
  logic        yneg_r, yneg_nxt, empty_r, empty_nxt, bis_r, bis_nxt;
  logic [5:0]  k_r, k_nxt;
  logic signed [63:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt, p4_r, p4_nxt;
  logic signed [33:0] lxs_r, lxs_nxt, lys_r, lys_nxt, rxs_r, rxs_nxt, rys_r, rys_nxt;

  // result register
  logic        ovalid_r, ovalid_nxt, olast_r, olast_nxt, oempty_r, oempty_nxt;
  logic [31:0] olx_r, olx_nxt, oly_r, oly_nxt, orx_r, orx_nxt, ory_r, ory_nxt;
  logic [30:0] ohrs_r, ohrs_nxt, ohd_r, ohd_nxt;
  logic [5:0]  oidx_r, oidx_nxt;

  iter_req_t   req;
  iter_sts_t   sts;
  logic [65:0] opa;
  logic [32:0] opb;
  logic [63:0] ires;
  logic        is_op;

  // accept-time decode
  logic [31:0] in_ax, in_ay, in_bx, in_by;
  logic [30:0] in_ua, in_ub;
  logic [32:0] dx, dy, ndx, ndy, smx, smy;
  logic [31:0] c_w, lma, lma_mag;
  logic [4:0]  h_w;
  logic [5:0]  plast_w, kinc;
  logic [32:0] stepv;
  logic [63:0] mres_neg;
  logic signed [63:0] rnd;
  logic        out_free, last_pt;

  assign in_ax = in_tdata[31:0];
  assign in_ay = in_tdata[63:32];
  assign in_bx = in_tdata[95:64];
  assign in_by = in_tdata[127:96];
  assign in_ua = in_tdata[158:128];
  assign in_ub = in_tdata[189:159];

  assign dx  = {in_bx[31], in_bx} - {in_ax[31], in_ax};
  assign dy  = {in_by[31], in_by} - {in_ay[31], in_ay};
  assign ndx = -dx;
  assign ndy = -dy;
  assign smx = {in_ax[31], in_ax} + {in_bx[31], in_bx};
  assign smy = {in_ay[31], in_ay} + {in_by[31], in_by};

  assign c_w      = dist_r[32:1];
  assign h_w      = pc_r[5:1];
  assign plast_w  = {pc_r[5:1], 1'b0};
  assign lma      = {1'b0, le_r} - {1'b0, a_r};
  assign lma_mag  = lma[31] ? -lma : lma;
  assign kinc     = k_r + 6'd1;
  assign stepv    = stepneg_r ? -{1'b0, stepm_r} : {1'b0, stepm_r};
  assign mres_neg = -ires;
  assign rnd      = 64'sd1 <<< (ROT_BITS - 1);
  assign out_free = !ovalid_r || out_tready;
  assign last_pt  = empty_r || (bis_r ? (k_r == 6'd3) : (k_r == plast_w));

  // operation select for the shared unit
  always_comb begin
    is_op  = 1'b1;
    req.op = OP_MUL;
    opa    = '0;
    opb    = '0;
    case (state_r)
      S_SQX:   begin opa = {34'b0, qx_r}; opb = {1'b0, qx_r}; end
      S_SQY:   begin opa = {34'b0, qy_r}; opb = {1'b0, qy_r}; end
      S_DIST:  begin req.op = OP_SQRT; opa = {1'b0, sum_r}; end
      S_CS:    begin
        req.op = OP_DIV; opa = {4'b0, qx_r, 30'b0}; opb = dist_r;
      end
      S_SN:    begin
        req.op = OP_DIV; opa = {4'b0, qy_r, 30'b0}; opb = dist_r;
      end
      S_A2:    begin opa = {35'b0, a_r}; opb = {2'b0, a_r}; end
      S_C2:    begin opa = {34'b0, c_w}; opb = {1'b0, c_w}; end
      S_BF:    begin req.op = OP_SQRT; opa = {2'b0, tmp_r - {2'b0, a2_r}}; end
      S_STEP:  begin req.op = OP_DIV; opa = {34'b0, lma_mag}; opb = {28'b0, h_w}; end
      S_XSQ:   begin opa = {35'b0, xc_r}; opb = {2'b0, xc_r}; end
      S_YSQRT: begin req.op = OP_SQRT; opa = {2'b0, tmp_r - {2'b0, a2_r}}; end
      S_YMUL:  begin opa = {34'b0, bf_r}; opb = {2'b0, ym_r}; end
      S_YDIV:  begin req.op = OP_DIV; opa = {2'b0, tmp_r}; opb = {2'b0, a_r}; end
      S_R1:    begin opa = {35'b0, csm_r}; opb = {2'b0, xc_r}; end
      S_R2:    begin opa = {35'b0, snm_r}; opb = {2'b0, ym_r}; end
      S_R3:    begin opa = {35'b0, snm_r}; opb = {2'b0, xc_r}; end
      S_R4:    begin opa = {35'b0, csm_r}; opb = {2'b0, ym_r}; end
      default: is_op = 1'b0;
    endcase
    req.start = is_op && !iss_r && !sts.busy;
  end

  uvep_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (req),
    .opa_i (opa),
    .opb_i (opb),
    .sts_o (sts),
    .res_o (ires)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;   iss_nxt = iss_r;
    pc_nxt = pc_r;         le_nxt = le_r;
    qx_nxt = qx_r;   qy_nxt = qy_r;   mx_nxt = mx_r;   my_nxt = my_r;
    sgx_nxt = sgx_r; sgy_nxt = sgy_r; a_nxt = a_r;     sum_nxt = sum_r;
    dist_nxt = dist_r; csm_nxt = csm_r; snm_nxt = snm_r; a2_nxt = a2_r;
    tmp_nxt = tmp_r; bf_nxt = bf_r;   stepm_nxt = stepm_r; stepneg_nxt = stepneg_r;
    xr_nxt = xr_r;   xc_nxt = xc_r;   ym_nxt = ym_r;   yneg_nxt = yneg_r;
    empty_nxt = empty_r; bis_nxt = bis_r; k_nxt = k_r;
    p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r; p4_nxt = p4_r;
    lxs_nxt = lxs_r; lys_nxt = lys_r; rxs_nxt = rxs_r; rys_nxt = rys_r;
    ovalid_nxt = ovalid_r; olast_nxt = olast_r; oempty_nxt = oempty_r;
    olx_nxt = olx_r; oly_nxt = oly_r; orx_nxt = orx_r; ory_nxt = ory_r;
    ohrs_nxt = ohrs_r; ohd_nxt = ohd_r; oidx_nxt = oidx_r;

    if (cfg_we) begin
      if (cfg_index == REG_POINT_COUNT) pc_nxt = cfg_wdata[5:0];
      else                              le_nxt = cfg_wdata;
    end

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    if (req.start) iss_nxt = 1'b1;
    if (sts.done)  iss_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          qx_nxt    = dx[32] ? ndx[31:0] : dx[31:0];
          qy_nxt    = dy[32] ? ndy[31:0] : dy[31:0];
          sgx_nxt   = dx[32];
          sgy_nxt   = dy[32];
          mx_nxt    = smx[32:1];
          my_nxt    = smy[32:1];
          a_nxt     = 31'(({1'b0, in_ua} + {1'b0, in_ub}) >> 1);
          empty_nxt = 1'b0;
          bis_nxt   = 1'b0;
          k_nxt     = '0;
          state_nxt = S_SQX;
        end
      end
      S_SQX: if (sts.done) begin sum_nxt = {1'b0, ires}; state_nxt = S_SQY; end
      S_SQY: if (sts.done) begin sum_nxt = sum_r + {1'b0, ires}; state_nxt = S_DIST; end
      S_DIST: begin
        if (sts.done) begin
          dist_nxt = ires[32:0];
          if (ires[32:1] <= {1'b0, a_r}) begin
            empty_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_CS;
          end
        end
      end
      S_CS: if (sts.done) begin csm_nxt = ires[30:0]; state_nxt = S_SN; end
      S_SN: begin
        if (sts.done) begin
          snm_nxt = ires[30:0];
          if (a_r == '0) begin
            bis_nxt   = 1'b1;
            state_nxt = S_COL;
          end else begin
            state_nxt = S_A2;
          end
        end
      end
      S_A2: if (sts.done) begin a2_nxt = ires[61:0]; state_nxt = S_C2; end
      S_C2: if (sts.done) begin tmp_nxt = ires; state_nxt = S_BF; end
      S_BF: begin
        if (sts.done) begin
          bf_nxt      = ires[31:0];
          xr_nxt      = {2'b0, le_r};
          stepm_nxt   = '0;
          stepneg_nxt = 1'b0;
          state_nxt   = (h_w == '0) ? S_COL : S_STEP;
        end
      end
      S_STEP: begin
        if (sts.done) begin
          stepm_nxt   = ires[31:0];
          stepneg_nxt = lma[31];
          state_nxt   = S_COL;
        end
      end
      S_COL: begin
        state_nxt = S_R1;
        yneg_nxt  = 1'b0;
        ym_nxt    = '0;
        if (bis_r) begin
          xc_nxt = (k_r[1]) ? le_r : '0;
          ym_nxt = le_r;
          yneg_nxt = (k_r[1:0] == 2'd1) || (k_r[1:0] == 2'd2);
        end else if (k_r == {1'b0, h_w}) begin
          xc_nxt = a_r;
        end else begin
          xc_nxt   = xr_r[30:0];
          yneg_nxt = (k_r < {1'b0, h_w});
          if (xr_r[31:0] > {1'b0, a_r}) state_nxt = S_XSQ;
        end
      end
      S_XSQ: if (sts.done) begin tmp_nxt = ires; state_nxt = S_YSQRT; end
      S_YSQRT: if (sts.done) begin ym_nxt = ires[30:0]; state_nxt = S_YMUL; end
      S_YMUL: if (sts.done) begin tmp_nxt = ires; state_nxt = S_YDIV; end
      S_YDIV: begin
        if (sts.done) begin
          ym_nxt    = (|ires[63:31]) ? 31'h7FFFFFFF : ires[30:0];
          state_nxt = S_R1;
        end
      end
      S_R1: if (sts.done) begin
        p1_nxt = sgx_r ? mres_neg : ires; state_nxt = S_R2;
      end
      S_R2: if (sts.done) begin
        p2_nxt = (sgy_r ^ yneg_r) ? mres_neg : ires; state_nxt = S_R3;
      end
      S_R3: if (sts.done) begin
        p3_nxt = sgy_r ? mres_neg : ires; state_nxt = S_R4;
      end
      S_R4: if (sts.done) begin
        p4_nxt = (sgx_r ^ yneg_r) ? mres_neg : ires; state_nxt = S_SUM;
      end
      S_SUM: begin
        // rounded rotation, floor shift by ROT_BITS
        rxs_nxt   = 34'((p1_r - p2_r + rnd) >>> ROT_BITS);
        lxs_nxt   = 34'((-p1_r - p2_r + rnd) >>> ROT_BITS);
        rys_nxt   = 34'((p3_r + p4_r + rnd) >>> ROT_BITS);
        lys_nxt   = 34'((p4_r - p3_r + rnd) >>> ROT_BITS);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = last_pt;
          oempty_nxt = empty_r;
          ohrs_nxt   = a_r;
          ohd_nxt    = c_w[31] ? 31'h7FFFFFFF : c_w[30:0];
          if (empty_r) begin
            olx_nxt = '0; oly_nxt = '0; orx_nxt = '0; ory_nxt = '0; oidx_nxt = '0;
          end else begin
            olx_nxt  = sat32(35'(lxs_r) + 35'($signed(mx_r)));
            oly_nxt  = sat32(35'(lys_r) + 35'($signed(my_r)));
            orx_nxt  = sat32(35'(rxs_r) + 35'($signed(mx_r)));
            ory_nxt  = sat32(35'(rys_r) + 35'($signed(my_r)));
            oidx_nxt = k_r;
          end
          k_nxt = kinc;
          if (!bis_r) begin
            if (kinc < {1'b0, h_w})     xr_nxt = xr_r - stepv;
            else if (k_r > {1'b0, h_w}) xr_nxt = xr_r + stepv;
          end
          state_nxt = last_pt ? S_IDLE : S_COL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      iss_r    <= 1'b0;
      pc_r     <= 6'd21;
      le_r     <= 31'd6553600;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_r    <= iss_nxt;
      pc_r     <= pc_nxt;
      le_r     <= le_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r <= qx_nxt;   qy_r <= qy_nxt;   mx_r <= mx_nxt;   my_r <= my_nxt;
    sgx_r <= sgx_nxt; sgy_r <= sgy_nxt; a_r <= a_nxt;     sum_r <= sum_nxt;
    dist_r <= dist_nxt; csm_r <= csm_nxt; snm_r <= snm_nxt; a2_r <= a2_nxt;
    tmp_r <= tmp_nxt; bf_r <= bf_nxt;   stepm_r <= stepm_nxt; stepneg_r <= stepneg_nxt;
    xr_r <= xr_nxt;   xc_r <= xc_nxt;   ym_r <= ym_nxt;   yneg_r <= yneg_nxt;
    empty_r <= empty_nxt; bis_r <= bis_nxt; k_r <= k_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; p3_r <= p3_nxt; p4_r <= p4_nxt;
    lxs_r <= lxs_nxt; lys_r <= lys_nxt; rxs_r <= rxs_nxt; rys_r <= rys_nxt;
    olast_r <= olast_nxt; oempty_r <= oempty_nxt;
    olx_r <= olx_nxt; oly_r <= oly_nxt; orx_r <= orx_nxt; ory_r <= ory_nxt;
    ohrs_r <= ohrs_nxt; ohd_r <= ohd_nxt; oidx_r <= oidx_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oempty_r;
  assign out_tdata  = {4'b0, oidx_r, ohd_r, ohrs_r, ory_r, orx_r, oly_r, olx_r};

endmodule

// File: rtl/uvep_iter.sv
// Shared bit-serial unit: unsigned 32x32 multiply, 64/33 divide, 66-bit square root.
module uvep_iter (
  input  logic              clk,
  input  logic              rst_n,
  input  uvep_pkg::iter_req_t req_i,
  input  logic [65:0]       opa_i,
  input  logic [32:0]       opb_i,
  output uvep_pkg::iter_sts_t sts_o,
  output logic [63:0]       res_o
);
  import uvep_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  op_t         op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [65:0] acc_r, acc_nxt;
  logic [63:0] res_r, res_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [32:0] opb_r, opb_nxt;
  logic [35:0] dv_t, sq_t, sq_trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    opb_nxt  = opb_r;
    dv_t     = {rem_r[34:0], acc_r[63]};
    sq_t     = {rem_r[33:0], acc_r[65:64]};
    sq_trial = {1'b0, res_r[32:0], 2'b01};
    if (req_i.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = req_i.op;
      rem_nxt  = '0;
      res_nxt  = '0;
      case (req_i.op)
        OP_DIV: begin
          acc_nxt = {2'b0, opa_i[63:0]};
          opb_nxt = opb_i;
          cnt_nxt = DIV_ITERS - 7'd1;
        end
        OP_SQRT: begin
          acc_nxt = opa_i;
          cnt_nxt = SQRT_ITERS - 7'd1;
        end
        default: begin
          acc_nxt = {34'b0, opb_i[31:0]};
          opb_nxt = {1'b0, opa_i[31:0]};
          cnt_nxt = MUL_ITERS - 7'd1;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_DIV: begin
          if (dv_t >= {3'b0, opb_r}) begin
            rem_nxt = dv_t - {3'b0, opb_r};
            res_nxt = {res_r[62:0], 1'b1};
          end else begin
            rem_nxt = dv_t;
            res_nxt = {res_r[62:0], 1'b0};
          end
          acc_nxt = {acc_r[64:0], 1'b0};
        end
        OP_SQRT: begin
          if (sq_t >= sq_trial) begin
            rem_nxt = sq_t - sq_trial;
            res_nxt = {res_r[62:0], 1'b1};
          end else begin
            rem_nxt = sq_t;
            res_nxt = {res_r[62:0], 1'b0};
          end
          acc_nxt = {acc_r[63:0], 2'b00};
        end
        default: begin
          res_nxt = {res_r[62:0], 1'b0} + (acc_r[31] ? {32'b0, opb_r[31:0]} : 64'b0);
          acc_nxt = {acc_r[64:0], 1'b0};
        end
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    rem_r <= rem_nxt;
    opb_r <= opb_nxt;
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign res_o      = res_r;

endmodule
